// File: hdl/angular_pair_histogram_core_defines.svh
// Assertion macros shared by the angular pair histogram RTL.
`ifndef ANGULAR_PAIR_HISTOGRAM_CORE_DEFINES_SVH
`define ANGULAR_PAIR_HISTOGRAM_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held
`define APH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is held
`define APH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define APH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define APH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hdl/aph_pkg.sv
// Types, constants and edge-table functions of the angular pair histogram.
package aph_pkg;

    typedef logic [63:0] t_u64;

    localparam int S_W       = 34;   // separation cosine, signed Q.30
    localparam int W_W       = 48;   // weight product, Q16.32
    localparam int OUT_IDX_W = 5;
    localparam int OUT_VAL_W = 63;
    localparam int FRAC      = 52;   // edge-table working precision

    localparam t_u64 ONE_Q   = 64'd1 << FRAC;
    localparam t_u64 PI_E7   = 64'd31415926;
    localparam t_u64 MIN_DEN = 64'd180000000000;

    localparam logic signed [31:0] TRIG_MAX = 32'sd1073741824;
    localparam logic signed [31:0] TRIG_MIN = -32'sd1073741824;

    // One pair of sky points
    typedef struct packed {
        logic signed [31:0] sin_dec_a;
        logic signed [31:0] cos_dec_a;
        logic signed [31:0] sin_ra_a;
        logic signed [31:0] cos_ra_a;
        logic signed [31:0] sin_dec_b;
        logic signed [31:0] cos_dec_b;
        logic signed [31:0] sin_ra_b;
        logic signed [31:0] cos_ra_b;
        logic [23:0]        weight_a;
        logic [23:0]        weight_b;
        logic               last_pair;
    } t_in;

    // One dump word
    typedef struct packed {
        logic [OUT_IDX_W-1:0] counter_index;
        logic [OUT_VAL_W-1:0] counter_value;
        logic                 last_word;
    } t_out;

    // Token handed from cell to cell
    typedef struct packed {
        logic                  vld;
        logic                  last;
        logic                  too_small; // at or above the first edge
        logic                  claimed;   // already counted by an earlier stage
        logic signed [S_W-1:0] s;
        logic [W_W-1:0]        w;
    } t_link;

    // floor(a * b / 2^FRAC)
    function automatic t_u64 mulq(input t_u64 a, input t_u64 b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[FRAC +: 64];
    endfunction

    // ln(500) = 9 ln2 - ln(1.024), each ln as 2 atanh(p/q)
    function automatic t_u64 ln500_q();
        t_u64 t3;
        t_u64 s3;
        t_u64 t253;
        t_u64 s253;
        t3   = ONE_Q / 64'd3;
        s3   = '0;
        t253 = (ONE_Q * 64'd3) / 64'd253;
        s253 = '0;
        for (int k = 0; k < 40; k++) begin
            s3   = s3 + t3 / 64'(2 * k + 1);
            t3   = t3 / 64'd9;
            s253 = s253 + t253 / 64'(2 * k + 1);
            t253 = (t253 * 64'd9) / 64'd64009;
        end
        return 64'd9 * (64'd2 * s3) - 64'd2 * s253;
    endfunction

    // Smallest angle in radians, by restoring long division
    function automatic t_u64 min_q();
        t_u64 q;
        t_u64 rem;
        q   = '0;
        rem = PI_E7;
        for (int b = 0; b < FRAC; b++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= MIN_DEN) begin
                rem  = rem - MIN_DEN;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    localparam t_u64 LN500 = ln500_q();
    localparam t_u64 MIN_Q = min_q();

    // Q1.30 cosine edge for log-angle y = ln500 * i / bins
    function automatic logic signed [S_W-1:0] edge_from_y(input t_u64 y);
        t_u64 term;
        t_u64 e;
        t_u64 th;
        t_u64 t2;
        t_u64 c;
        term = ONE_Q;
        e    = ONE_Q;
        for (int k = 1; k <= 64; k++) begin
            term = mulq(term, y) / 64'(k);
            e    = e + term;
        end
        th   = mulq(MIN_Q, e);
        t2   = mulq(th, th);
        term = ONE_Q;
        c    = ONE_Q;
        for (int k = 1; k <= 12; k++) begin
            term = mulq(term, t2) / 64'((2 * k - 1) * (2 * k));
            if (k[0]) begin
                c = c - term;
            end else begin
                c = c + term;
            end
        end
        return S_W'((c + (64'd1 << 21)) >> 22);
    endfunction

    // Clamp a trig input to [-1, 1] in Q1.30
    function automatic logic signed [31:0] trig_clamp(input logic signed [31:0] x);
        logic signed [31:0] v;
        v = x;
        if (x > TRIG_MAX) begin
            v = TRIG_MAX;
        end else if (x < TRIG_MIN) begin
            v = TRIG_MIN;
        end
        return v;
    endfunction

endpackage

// File: hdl/angular_pair_histogram_core.sv
// Top level of the weighted angular pair histogram.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one point pair per
// transfer; output channel (o_out_valid / i_out_stall / o_out_data) gives dump
// words. Pairs stream in at one per cycle while the input is not stalled and
// produce no output until a pair marked last_pair. A pair passes a 4-stage
// product pipeline, then a row of NUM_BINS registered bin cells, then the tail
// counters. After a last pair is taken the input is stalled; the dump starts
// once that pair has left the chain, and gives NUM_BINS + 3 words (bins, too
// wide, too small, total) at one per cycle while the output is not stalled.
// Each dump word shifts the counter chain one place towards the output, so the
// counters are clear when the total word is taken. A stall on the output
// simply holds the chain and the current word. Input is taken again in the
// cycle after the final word's transfer.
// Reset (synchronous, active low) clears every counter and empties the chain.
`include "angular_pair_histogram_core_defines.svh"

module angular_pair_histogram_core #(
    parameter int NUM_BINS  = 27,
    parameter int ACC_WIDTH = 63
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  aph_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output aph_pkg::t_out o_out_data
);
    import aph_pkg::*;

    localparam int IDX_W = $clog2(NUM_BINS + 3);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BINS + 2);
    localparam logic signed [S_W-1:0] THRESH0 = edge_from_y(64'd0);

    t_link                w_link [NUM_BINS+1];
    logic [ACC_WIDTH-1:0] w_acc  [NUM_BINS+3];

    logic             r_hold, n_hold;
    logic             r_dump, n_dump;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             w_in_xfer, w_out_xfer, w_drained, w_final;

    assign w_in_xfer  = i_in_valid && !r_hold;
    assign w_out_xfer = r_dump && !i_out_stall;
    assign w_final    = w_out_xfer && (r_idx == IDX_LAST);
    assign w_drained  = w_link[NUM_BINS].vld && w_link[NUM_BINS].last;

    // separation cosine and weight product
    aph_sep_pipe #(
        .THRESH0 (THRESH0)
    ) u_sep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_in_xfer),
        .i_item  (i_in_data),
        .o_link  (w_link[0])
    );

    // row of bin cells; cell j has lower edge j+1
    for (genvar j = 0; j < NUM_BINS; j++) begin : g_cell
        localparam t_u64 Y = LN500 * t_u64'(j + 1) / t_u64'(NUM_BINS);
        aph_bin_cell #(
            .ACC_WIDTH (ACC_WIDTH),
            .THRESH    (edge_from_y(Y))
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_link     (w_link[j]),
            .o_link     (w_link[j+1]),
            .i_shift    (w_out_xfer),
            .i_shift_in (w_acc[j+1]),
            .o_acc      (w_acc[j])
        );
    end

    // too-wide, too-small and total counters
    aph_tail #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_tail (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_link[NUM_BINS]),
        .i_shift (w_out_xfer),
        .o_wide  (w_acc[NUM_BINS]),
        .o_small (w_acc[NUM_BINS+1]),
        .o_total (w_acc[NUM_BINS+2])
    );

    // input hold, dump state and word index
    always_comb begin
        n_hold = r_hold;
        n_dump = r_dump;
        n_idx  = r_idx;
        if (w_in_xfer && i_in_data.last_pair) begin
            n_hold = 1'b1;
        end else if (w_final) begin
            n_hold = 1'b0;
        end
        if (w_drained) begin
            n_dump = 1'b1;
        end else if (w_final) begin
            n_dump = 1'b0;
        end
        if (w_out_xfer) begin
            n_idx = w_final ? '0 : r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_dump <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_hold <= n_hold;
            r_dump <= n_dump;
            r_idx  <= n_idx;
        end
    end

    assign o_in_stall                = r_hold;
    assign o_out_valid               = r_dump;
    assign o_out_data.counter_index  = OUT_IDX_W'(r_idx);
    assign o_out_data.counter_value  = OUT_VAL_W'(w_acc[0]);
    assign o_out_data.last_word      = (r_idx == IDX_LAST);

    // checks
    `APH_ASSERT_IMPL(a_dump_stalls_input, i_clk, i_rst_n, o_out_valid, o_in_stall,
        "input not stalled during dump")
    `APH_ASSERT_IMPL(a_chain_empty_in_dump, i_clk, i_rst_n, o_out_valid,
        !w_link[0].vld && !w_link[NUM_BINS].vld, "pair in chain during dump")
    `APH_ASSERT_IMPL(a_dump_starts_at_bin0, i_clk, i_rst_n, $rose(o_out_valid),
        r_idx == '0, "dump does not start at the first bin")
    `APH_ASSERT_NEXT(a_dump_ends_clean, i_clk, i_rst_n, w_final,
        !o_out_valid && !o_in_stall && (w_acc[0] == '0), "dump end left state behind")

endmodule

// File: hdl/aph_sep_pipe.sv
// Four-stage pipeline forming the separation cosine and the weight product.
module aph_sep_pipe #(
    parameter logic signed [aph_pkg::S_W-1:0] THRESH0 = '0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  aph_pkg::t_in   i_item,
    output aph_pkg::t_link o_link
);
    import aph_pkg::*;

    // stage 1: clamped products
    logic signed [31:0] w_sda, w_cda, w_sra, w_cra, w_sdb, w_cdb, w_srb, w_crb;
    logic signed [63:0] w_ra_c, w_ra_s, w_dec_c, w_dec_s;
    logic [W_W-1:0]     w_w;
    logic               r1_vld, r1_last;
    logic signed [63:0] r1_ra_c, r1_ra_s, r1_dec_c, r1_dec_s;
    logic [W_W-1:0]     r1_w;

    // stage 2: r and d
    logic signed [63:0] w_ra_sum;
    logic               r2_vld, r2_last;
    logic signed [32:0] r2_r;
    logic signed [31:0] r2_d;
    logic signed [63:0] r2_dec_s;
    logic [W_W-1:0]     r2_w;

    // stage 3: d * r
    logic               r3_vld, r3_last;
    logic signed [64:0] r3_dr;
    logic signed [63:0] r3_dec_s;
    logic [W_W-1:0]     r3_w;

    // stage 4: separation cosine and the too-small test
    logic signed [65:0]    w_s_sum;
    logic signed [S_W-1:0] w_s;
    t_link                 n_link, r_link;

    assign w_sda = trig_clamp(i_item.sin_dec_a);
    assign w_cda = trig_clamp(i_item.cos_dec_a);
    assign w_sra = trig_clamp(i_item.sin_ra_a);
    assign w_cra = trig_clamp(i_item.cos_ra_a);
    assign w_sdb = trig_clamp(i_item.sin_dec_b);
    assign w_cdb = trig_clamp(i_item.cos_dec_b);
    assign w_srb = trig_clamp(i_item.sin_ra_b);
    assign w_crb = trig_clamp(i_item.cos_ra_b);

    assign w_ra_c  = w_cra * w_crb;
    assign w_ra_s  = w_sra * w_srb;
    assign w_dec_c = w_cda * w_cdb;
    assign w_dec_s = w_sda * w_sdb;
    assign w_w     = i_item.weight_a * i_item.weight_b;

    assign w_ra_sum = r1_ra_c + r1_ra_s;

    assign w_s_sum = r3_dr + r3_dec_s;
    assign w_s     = w_s_sum[S_W+29:30];

    always_comb begin
        n_link           = r_link;
        n_link.vld       = r3_vld;
        n_link.last      = r3_last;
        n_link.s         = w_s;
        n_link.w         = r3_w;
        n_link.too_small = (w_s >= THRESH0);
        n_link.claimed   = (w_s >= THRESH0);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld     <= 1'b0;
            r2_vld     <= 1'b0;
            r3_vld     <= 1'b0;
            r_link.vld <= 1'b0;
        end else begin
            r1_vld     <= i_vld;
            r2_vld     <= r1_vld;
            r3_vld     <= r2_vld;
            r_link.vld <= n_link.vld;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r1_last  <= i_item.last_pair;
        r1_ra_c  <= w_ra_c;
        r1_ra_s  <= w_ra_s;
        r1_dec_c <= w_dec_c;
        r1_dec_s <= w_dec_s;
        r1_w     <= w_w;

        r2_last  <= r1_last;
        r2_r     <= w_ra_sum[62:30];
        r2_d     <= r1_dec_c[61:30];
        r2_dec_s <= r1_dec_s;
        r2_w     <= r1_w;

        r3_last  <= r2_last;
        r3_dr    <= r2_d * r2_r;
        r3_dec_s <= r2_dec_s;
        r3_w     <= r2_w;

        r_link.last      <= n_link.last;
        r_link.too_small <= n_link.too_small;
        r_link.claimed   <= n_link.claimed;
        r_link.s         <= n_link.s;
        r_link.w         <= n_link.w;
    end

    assign o_link = r_link;

endmodule

// File: hdl/aph_bin_cell.sv
// One histogram bin: edge compare, saturating accumulator and dump shift stage.
module aph_bin_cell #(
    parameter int ACC_WIDTH = 63,
    parameter logic signed [aph_pkg::S_W-1:0] THRESH = '0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aph_pkg::t_link       i_link,
    output aph_pkg::t_link       o_link,
    input  logic                 i_shift,
    input  logic [ACC_WIDTH-1:0] i_shift_in,
    output logic [ACC_WIDTH-1:0] o_acc
);
    import aph_pkg::*;

    logic                 w_hit;
    logic [ACC_WIDTH:0]   w_sum;
    logic [ACC_WIDTH-1:0] r_acc, n_acc;
    t_link                r_link, n_link;

    // first unclaimed token at or above this lower edge belongs here
    assign w_hit = i_link.vld && !i_link.claimed && ($signed(i_link.s) >= THRESH);
    assign w_sum = {1'b0, r_acc} + (ACC_WIDTH + 1)'(i_link.w);

    always_comb begin
        n_acc = r_acc;
        if (i_shift) begin
            n_acc = i_shift_in;
        end else if (w_hit) begin
            n_acc = w_sum[ACC_WIDTH] ? '1 : w_sum[ACC_WIDTH-1:0];
        end
    end

    always_comb begin
        n_link         = i_link;
        n_link.claimed = i_link.claimed | w_hit;
    end

    // accumulator and token valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_link.vld <= 1'b0;
        end else begin
            r_acc      <= n_acc;
            r_link.vld <= n_link.vld;
        end
    end

    // token payload
    always_ff @(posedge i_clk) begin
        r_link.last      <= n_link.last;
        r_link.too_small <= n_link.too_small;
        r_link.claimed   <= n_link.claimed;
        r_link.s         <= n_link.s;
        r_link.w         <= n_link.w;
    end

    assign o_link = r_link;
    assign o_acc  = r_acc;

endmodule

// File: hdl/aph_tail.sv
// End of the chain: too-wide, too-small and total counters.
module aph_tail #(
    parameter int ACC_WIDTH = 63
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aph_pkg::t_link       i_link,
    input  logic                 i_shift,
    output logic [ACC_WIDTH-1:0] o_wide,
    output logic [ACC_WIDTH-1:0] o_small,
    output logic [ACC_WIDTH-1:0] o_total
);
    import aph_pkg::*;

    logic [ACC_WIDTH-1:0] r_wide, r_small, r_total;
    logic [ACC_WIDTH-1:0] n_wide, n_small, n_total;

    function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] acc,
                                                     input logic [W_W-1:0] w);
        logic [ACC_WIDTH:0] sum;
        sum = {1'b0, acc} + (ACC_WIDTH + 1)'(w);
        return sum[ACC_WIDTH] ? '1 : sum[ACC_WIDTH-1:0];
    endfunction

    // dump shifts wide <- small <- total <- zero, so the tail clears itself
    always_comb begin
        n_wide  = r_wide;
        n_small = r_small;
        n_total = r_total;
        if (i_shift) begin
            n_wide  = r_small;
            n_small = r_total;
            n_total = '0;
        end else if (i_link.vld) begin
            n_total = sat_add(r_total, i_link.w);
            if (i_link.too_small) begin
                n_small = sat_add(r_small, i_link.w);
            end else if (!i_link.claimed) begin
                n_wide = sat_add(r_wide, i_link.w);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide  <= '0;
            r_small <= '0;
            r_total <= '0;
        end else begin
            r_wide  <= n_wide;
            r_small <= n_small;
            r_total <= n_total;
        end
    end

    assign o_wide  = r_wide;
    assign o_small = r_small;
    assign o_total = r_total;

endmodule
